// ----- sv/joystick_to_drive_command_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the joystick to drive command unit
// Shared helpers for concurrent checks, gated off while reset is low.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_TO_DRIVE_COMMAND_UNIT_DEFINES_SVH
`define JOYSTICK_TO_DRIVE_COMMAND_UNIT_DEFINES_SVH

// same-cycle implication
`define JDC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jdc: check failed");

// next-cycle implication
`define JDC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jdc: check failed");

`endif

// ----- sv/jdc_pkg.sv -----
// ----------------------------------------------------------------------------
// jdc_pkg
// Types and constants shared by the drive command datapath and its units.
// ----------------------------------------------------------------------------
package jdc_pkg;

    localparam int MUL_W = 9;             // multiplier operand width
    localparam int PROD_W = 2 * MUL_W;    // multiplier product width
    localparam int ACC_W = 17;            // subtractor width

    // drive commands
    localparam logic [3:0] CMD_STOP    = 4'd0;
    localparam logic [3:0] CMD_RIGHT   = 4'd1;
    localparam logic [3:0] CMD_D45     = 4'd2;
    localparam logic [3:0] CMD_FORWARD = 4'd3;
    localparam logic [3:0] CMD_D135    = 4'd4;
    localparam logic [3:0] CMD_LEFT    = 4'd5;
    localparam logic [3:0] CMD_D225    = 4'd6;
    localparam logic [3:0] CMD_BACK    = 4'd7;
    localparam logic [3:0] CMD_D315    = 4'd8;
    localparam logic [3:0] CMD_ROT_CCW = 4'd9;
    localparam logic [3:0] CMD_ROT_CW  = 4'd10;

    // configuration register indexes
    localparam logic [1:0] REG_DEADZONE = 2'd0;
    localparam logic [1:0] REG_LIMIT    = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;

    localparam logic [7:0]  RST_DEADZONE = 8'd10;
    localparam logic [7:0]  RST_LIMIT    = 8'd255;
    localparam logic [15:0] RST_INTERVAL = 16'd50;

    localparam logic [9:0] SPEED_MAX = 10'd512;
    localparam logic [6:0] SPEED_DIV = 7'd127;

    typedef struct packed {
        logic             ge;     // minuend >= subtrahend
        logic [ACC_W-1:0] diff;
    } t_alu_res;

    // magnitude of an 8-bit two's complement value, 128 included
    function automatic logic [8:0] abs9(input logic [7:0] v);
        logic [8:0] ext;
        ext = {v[7], v};
        return v[7] ? (~ext + 9'd1) : ext;
    endfunction

endpackage

// ----- sv/jdc_mul.sv -----
// ----------------------------------------------------------------------------
// jdc_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module jdc_mul (
    input  logic                        i_clk,
    input  logic [jdc_pkg::MUL_W-1:0]   i_a,
    input  logic [jdc_pkg::MUL_W-1:0]   i_b,
    output logic [jdc_pkg::PROD_W-1:0]  o_prod
);

    logic [jdc_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= jdc_pkg::PROD_W'(i_a) * jdc_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ----- sv/jdc_alu.sv -----
// ----------------------------------------------------------------------------
// jdc_alu
// Shared compare-and-subtract step for the square root and divide loops.
// ----------------------------------------------------------------------------
module jdc_alu (
    input  logic [jdc_pkg::ACC_W-1:0] i_p,
    input  logic [jdc_pkg::ACC_W-1:0] i_q,
    output jdc_pkg::t_alu_res         o_res
);

    logic [jdc_pkg::ACC_W:0] w_sub;

    assign w_sub = {1'b0, i_p} - {1'b0, i_q};
    // no borrow out means p >= q
    assign o_res.ge   = ~w_sub[jdc_pkg::ACC_W];
    assign o_res.diff = w_sub[jdc_pkg::ACC_W-1:0];

endmodule

// ----- sv/joystick_to_drive_command_unit.sv -----
// ----------------------------------------------------------------------------
// joystick_to_drive_command_unit
// Turns gamepad samples into rate-limited drive commands with a speed.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake                  | payload
//  s_axis    | in  | i_s_axis_tvalid/o_..tready | sticks, triggers, now_ms
//  m_axis    | out | o_m_axis_tvalid/i_..tready | command, speed
//  cfg       | in  | i_cfg_valid/o_cfg_ready    | i_cfg_index, i_cfg_data
//
//  A stick sample runs from its accept through three squares on the shared
//  multiplier, 8 root steps on the shared subtractor, the scale product, then
//  two folds and one subtract for the divide by 127; a trigger sample starts
//  at the scale product, an idle one at decide; the next beat is taken after.
//  Synchronous active-low reset clears control and history, sets config defaults.
//  A result waits in the output register; a later sample stalls only in its
//  decide step while that beat is still unread.
// ----------------------------------------------------------------------------
`include "joystick_to_drive_command_unit_defines.svh"

module joystick_to_drive_command_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // [7:0] left_x, [15:8] left_y, [23:16] right_x, [31:24] right_y,
    // [39:32] left_trigger, [47:40] right_trigger, [79:48] now_ms
    input  logic [79:0] i_s_axis_tdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [3:0] command, [13:4] speed, [15:14] zero
    output logic [15:0] o_m_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_SQA    = 10'b00_0000_0010,
        S_SQB    = 10'b00_0000_0100,
        S_SQS    = 10'b00_0000_1000,
        S_SQR    = 10'b00_0001_0000,
        S_ROOT   = 10'b00_0010_0000,
        S_SCALE  = 10'b00_0100_0000,
        S_DIVLD  = 10'b00_1000_0000,
        S_DIV    = 10'b01_0000_0000,
        S_DECIDE = 10'b10_0000_0000
    } t_state;

    localparam int ACC_W = jdc_pkg::ACC_W;
    localparam int MUL_W = jdc_pkg::MUL_W;

    t_state r_state, n_state;

    // configuration
    logic [7:0]  r_deadzone, n_deadzone;
    logic [7:0]  r_limit, n_limit;
    logic [15:0] r_interval, n_interval;

    // history
    logic [31:0] r_last_time, n_last_time;
    logic [3:0]  r_last_cmd, n_last_cmd;
    logic [9:0]  r_last_spd, n_last_spd;
    logic        r_sent, n_sent;
    logic        r_ovalid, n_ovalid;

    // working registers
    logic [31:0]      r_now, n_now;
    logic [8:0]       r_a, n_a;
    logic [8:0]       r_b, n_b;
    logic             r_left, n_left;
    logic             r_xneg, n_xneg;
    logic             r_ypos, n_ypos;
    logic [3:0]       r_cmd, n_cmd;
    logic [14:0]      r_a2, n_a2;
    logic [14:0]      r_b2, n_b2;
    logic [16:0]      r_s2, n_s2;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [ACC_W-1:0] r_root, n_root;
    logic [3:0]       r_cnt, n_cnt;
    logic [7:0]       r_mag, n_mag;
    logic [9:0]       r_quot, n_quot;
    logic [3:0]       r_out_cmd, n_out_cmd;
    logic [9:0]       r_out_spd, n_out_spd;

    // input fields
    logic [7:0]  w_lx, w_ly, w_rx, w_ry, w_lt, w_rt;
    logic [31:0] w_now_in;
    logic [8:0]  w_lxa, w_lya, w_rxa, w_rya;
    logic        w_left_on, w_right_on, w_in_acc;

    // shared units
    logic [MUL_W-1:0]          w_mul_a, w_mul_b;
    logic [jdc_pkg::PROD_W-1:0] w_prod;
    logic [ACC_W-1:0]          w_alu_p, w_alu_q;
    jdc_pkg::t_alu_res         w_alu;

    logic [ACC_W-1:0] w_bit, w_root_q, w_div_q, w_root_nx;
    logic [8:0]       w_ab;
    logic [31:0]      w_elapsed;
    logic             w_pass, w_changed;
    logic [3:0]       w_cmd_fin;

    assign w_lx     = i_s_axis_tdata[7:0];
    assign w_ly     = i_s_axis_tdata[15:8];
    assign w_rx     = i_s_axis_tdata[23:16];
    assign w_ry     = i_s_axis_tdata[31:24];
    assign w_lt     = i_s_axis_tdata[39:32];
    assign w_rt     = i_s_axis_tdata[47:40];
    assign w_now_in = i_s_axis_tdata[79:48];

    assign w_lxa = jdc_pkg::abs9(w_lx);
    assign w_lya = jdc_pkg::abs9(w_ly);
    assign w_rxa = jdc_pkg::abs9(w_rx);
    assign w_rya = jdc_pkg::abs9(w_ry);

    assign w_left_on  = (w_lxa > {1'b0, r_deadzone}) || (w_lya > {1'b0, r_deadzone});
    assign w_right_on = (w_rxa > {1'b0, r_deadzone}) || (w_rya > {1'b0, r_deadzone});

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // root step: bit = 4^k, k counts down from 7
    assign w_bit     = ACC_W'(1) << {r_cnt[2:0], 1'b0};
    assign w_root_q  = r_root + w_bit;
    assign w_div_q   = ACC_W'(jdc_pkg::SPEED_DIV);
    assign w_root_nx = w_alu.ge ? ((r_root >> 1) + w_bit) : (r_root >> 1);
    assign w_ab      = r_a + r_b;

    assign w_alu_p = r_acc;
    assign w_alu_q = (r_state == S_ROOT) ? w_root_q : w_div_q;

    always_comb begin
        unique case (r_state)
            S_SQA: begin
                w_mul_a = r_a;
                w_mul_b = r_a;
            end
            S_SQB: begin
                w_mul_a = r_b;
                w_mul_b = r_b;
            end
            S_SQS: begin
                w_mul_a = w_ab;
                w_mul_b = w_ab;
            end
            default: begin
                w_mul_a = {1'b0, r_mag};
                w_mul_b = {1'b0, r_limit};
            end
        endcase
    end

    jdc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    jdc_alu u_alu (
        .i_p   (w_alu_p),
        .i_q   (w_alu_q),
        .o_res (w_alu)
    );

    // sector of (-x, y) for the left stick; otherwise the command chosen at accept
    always_comb begin
        if (!r_left) begin
            w_cmd_fin = r_cmd;
        end else if (r_s2 < {1'b0, r_a2, 1'b0}) begin
            w_cmd_fin = r_xneg ? jdc_pkg::CMD_RIGHT : jdc_pkg::CMD_LEFT;
        end else if (r_s2 < {1'b0, r_b2, 1'b0}) begin
            w_cmd_fin = r_ypos ? jdc_pkg::CMD_FORWARD : jdc_pkg::CMD_BACK;
        end else if (r_xneg) begin
            w_cmd_fin = r_ypos ? jdc_pkg::CMD_D45 : jdc_pkg::CMD_D315;
        end else begin
            w_cmd_fin = r_ypos ? jdc_pkg::CMD_D135 : jdc_pkg::CMD_D225;
        end
    end

    assign w_elapsed = r_now - r_last_time;
    assign w_pass    = (w_elapsed >= {16'd0, r_interval});
    assign w_changed = !r_sent || (w_cmd_fin != r_last_cmd) || (r_quot != r_last_spd);

    always_comb begin
        n_state     = r_state;
        n_deadzone  = r_deadzone;
        n_limit     = r_limit;
        n_interval  = r_interval;
        n_last_time = r_last_time;
        n_last_cmd  = r_last_cmd;
        n_last_spd  = r_last_spd;
        n_sent      = r_sent;
        n_ovalid    = r_ovalid && !i_m_axis_tready;
        n_now       = r_now;
        n_a         = r_a;
        n_b         = r_b;
        n_left      = r_left;
        n_xneg      = r_xneg;
        n_ypos      = r_ypos;
        n_cmd       = r_cmd;
        n_a2        = r_a2;
        n_b2        = r_b2;
        n_s2        = r_s2;
        n_acc       = r_acc;
        n_root      = r_root;
        n_cnt       = r_cnt;
        n_mag       = r_mag;
        n_quot      = r_quot;
        n_out_cmd   = r_out_cmd;
        n_out_spd   = r_out_spd;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                jdc_pkg::REG_DEADZONE: n_deadzone = i_cfg_data[7:0];
                jdc_pkg::REG_LIMIT:    n_limit    = i_cfg_data[7:0];
                jdc_pkg::REG_INTERVAL: n_interval = i_cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_now  = w_now_in;
                    n_left = w_left_on;
                    n_xneg = w_lx[7];
                    n_ypos = !w_ly[7] && (w_ly != 8'd0);
                    n_a    = w_left_on ? w_lxa : w_rxa;
                    n_b    = w_left_on ? w_lya : w_rya;
                    n_quot = 10'd0;
                    priority if (w_left_on) begin
                        n_cmd   = jdc_pkg::CMD_STOP;
                        n_state = S_SQA;
                    end else if (w_right_on) begin
                        n_cmd   = (!w_rx[7] && (w_rx != 8'd0) && (w_ry[7] || (w_ry == 8'd0)))
                                  ? jdc_pkg::CMD_ROT_CCW : jdc_pkg::CMD_ROT_CW;
                        n_state = S_SQA;
                    end else if (w_lt > r_deadzone) begin
                        n_mag   = w_lt;
                        n_cmd   = jdc_pkg::CMD_ROT_CCW;
                        n_state = S_SCALE;
                    end else if (w_rt > r_deadzone) begin
                        n_mag   = w_rt;
                        n_cmd   = jdc_pkg::CMD_ROT_CW;
                        n_state = S_SCALE;
                    end else begin
                        n_cmd   = jdc_pkg::CMD_STOP;
                        n_state = S_DECIDE;
                    end
                end
            end
            S_SQA: begin
                n_state = S_SQB;
            end
            S_SQB: begin
                n_a2    = w_prod[14:0];
                n_state = S_SQS;
            end
            S_SQS: begin
                n_b2    = w_prod[14:0];
                n_state = S_SQR;
            end
            S_SQR: begin
                n_s2    = w_prod[16:0];
                n_acc   = ACC_W'(r_a2) + ACC_W'(r_b2);
                n_root  = '0;
                n_cnt   = 4'd7;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (w_alu.ge) begin
                    n_acc = w_alu.diff;
                end
                n_root = w_root_nx;
                if (r_cnt == 4'd0) begin
                    n_mag   = w_root_nx[7:0];
                    n_state = S_SCALE;
                end else begin
                    n_cnt = r_cnt - 4'd1;
                end
            end
            S_SCALE: begin
                n_state = S_DIVLD;
            end
            S_DIVLD: begin
                n_acc   = w_prod[ACC_W-1:0];
                n_cnt   = 4'd2;
                n_quot  = 10'd0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == 4'd0) begin
                    // at most 131 is left: one compare and subtract against 127
                    if (w_alu.ge) begin
                        n_acc  = w_alu.diff;
                        n_quot = r_quot + 10'd1;
                    end
                    n_state = S_DECIDE;
                end else begin
                    // fold 128h + l into 127h + (h + l)
                    n_acc  = ACC_W'(r_acc[ACC_W-1:7]) + ACC_W'(r_acc[6:0]);
                    n_quot = r_quot + r_acc[ACC_W-1:7];
                    n_cnt  = r_cnt - 4'd1;
                end
            end
            S_DECIDE: begin
                // hold while the previous beat is still unread
                if (!r_ovalid || i_m_axis_tready) begin
                    n_state = S_IDLE;
                    if (w_pass) begin
                        n_last_time = r_now;
                        if (w_changed) begin
                            n_sent     = 1'b1;
                            n_last_cmd = w_cmd_fin;
                            n_last_spd = r_quot;
                            n_out_cmd  = w_cmd_fin;
                            n_out_spd  = r_quot;
                            n_ovalid   = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_deadzone  <= jdc_pkg::RST_DEADZONE;
            r_limit     <= jdc_pkg::RST_LIMIT;
            r_interval  <= jdc_pkg::RST_INTERVAL;
            r_last_time <= '0;
            r_last_cmd  <= jdc_pkg::CMD_STOP;
            r_last_spd  <= '0;
            r_sent      <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_deadzone  <= n_deadzone;
            r_limit     <= n_limit;
            r_interval  <= n_interval;
            r_last_time <= n_last_time;
            r_last_cmd  <= n_last_cmd;
            r_last_spd  <= n_last_spd;
            r_sent      <= n_sent;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now     <= n_now;
        r_a       <= n_a;
        r_b       <= n_b;
        r_left    <= n_left;
        r_xneg    <= n_xneg;
        r_ypos    <= n_ypos;
        r_cmd     <= n_cmd;
        r_a2      <= n_a2;
        r_b2      <= n_b2;
        r_s2      <= n_s2;
        r_acc     <= n_acc;
        r_root    <= n_root;
        r_cnt     <= n_cnt;
        r_mag     <= n_mag;
        r_quot    <= n_quot;
        r_out_cmd <= n_out_cmd;
        r_out_spd <= n_out_spd;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {2'b00, r_out_spd, r_out_cmd};

    `JDC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, !o_s_axis_tready)
    `JDC_ASSERT_IMP(a_cmd_range, i_clk, i_rst_n, r_ovalid, r_out_cmd <= jdc_pkg::CMD_ROT_CW)
    `JDC_ASSERT_IMP(a_speed_range, i_clk, i_rst_n, r_ovalid, r_out_spd <= jdc_pkg::SPEED_MAX)
    `JDC_ASSERT_IMP(a_valid_needs_sent, i_clk, i_rst_n, r_ovalid, r_sent)
    `JDC_ASSERT_IMP(a_new_beat_is_history, i_clk, i_rst_n, $rose(r_ovalid),
        (r_out_cmd == r_last_cmd) && (r_out_spd == r_last_spd))

endmodule

// ----- tb/joystick_to_drive_command_unit_tb.sv -----
// ----------------------------------------------------------------------------
// joystick_to_drive_command_unit_tb
// Feeds gamepad samples through the stream input under several register
// settings and idle patterns, works out the drive command and speed of each
// accepted sample, and checks every output beat against the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module joystick_to_drive_command_unit_tb;

    localparam int LIMIT = 4000;        // cycles with no beat on any channel
    localparam int SETTLE = 64;         // covers the longest sample without a result
    localparam int STALL_LEN = 400;
    localparam logic [1:0] REG_SPARE = 2'd3;

    // fields from the lowest bit up: left_x first, now_ms last
    typedef struct packed {
        logic [31:0] now_ms;
        logic [7:0]  right_trigger;
        logic [7:0]  left_trigger;
        logic [7:0]  right_y;
        logic [7:0]  right_x;
        logic [7:0]  left_y;
        logic [7:0]  left_x;
    } t_sample;

    typedef struct packed {
        logic [9:0] speed;
        logic [3:0] cmd;
    } t_drive_beat;

    logic        i_clk;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    t_sample     s_item = '0;
    logic        s_taken = 1'b0;
    logic        m_ready = 1'b0;
    logic        hold_rx = 1'b0;
    logic        pressure_go = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    logic        o_s_axis_tready;
    logic [15:0] o_m_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        o_cfg_ready;

    // predictor copy of the registers and the send history
    logic [7:0]  dz_cfg = jdc_pkg::RST_DEADZONE;
    logic [7:0]  limit_cfg = jdc_pkg::RST_LIMIT;
    logic [15:0] interval_cfg = jdc_pkg::RST_INTERVAL;
    logic [31:0] sent_time = '0;
    logic [3:0]  sent_cmd = jdc_pkg::CMD_STOP;
    logic [9:0]  sent_speed = '0;
    logic        sent_once = 1'b0;

    t_sample     sample_q[$];
    t_drive_beat drive_expect_q[$];
    t_drive_beat got_beat, want_beat;
    t_sample     last_made = '0;
    logic [31:0] clk_ms = '0;
    int          send_idle_pct = 12;
    int          recv_idle_pct = 85;
    int          fail_count = 0;
    int          quiet_cycles = 0;

    joystick_to_drive_command_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (s_item),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor
    function automatic int iabs(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int root_floor(input int n);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= n) r++;
        return r;
    endfunction

    function automatic logic [9:0] scaled(input int mag);
        return 10'((mag * int'(limit_cfg)) / 127);
    endfunction

    // eight sectors of the direction (-x, y), split exactly at 22.5 degrees
    function automatic logic [3:0] compass(input int x, input int y);
        int u, a, b, s;
        u = -x;
        a = iabs(u);
        b = iabs(y);
        s = (a + b) * (a + b);
        if (s < 2 * a * a)
            return (u > 0) ? jdc_pkg::CMD_RIGHT : jdc_pkg::CMD_LEFT;
        if (s < 2 * b * b)
            return (y > 0) ? jdc_pkg::CMD_FORWARD : jdc_pkg::CMD_BACK;
        if (u > 0)
            return (y > 0) ? jdc_pkg::CMD_D45 : jdc_pkg::CMD_D315;
        return (y > 0) ? jdc_pkg::CMD_D135 : jdc_pkg::CMD_D225;
    endfunction

    task automatic decide_drive(input t_sample smp);
        int lx, ly, rx, ry, dz;
        logic [3:0]  cmd;
        logic [9:0]  spd;
        logic [31:0] gap;
        t_drive_beat beat;
        lx = $signed(smp.left_x);
        ly = $signed(smp.left_y);
        rx = $signed(smp.right_x);
        ry = $signed(smp.right_y);
        dz = int'(dz_cfg);
        if (iabs(lx) > dz || iabs(ly) > dz) begin
            spd = scaled(root_floor(lx * lx + ly * ly));
            cmd = compass(lx, ly);
        end else if (iabs(rx) > dz || iabs(ry) > dz) begin
            spd = scaled(root_floor(rx * rx + ry * ry));
            cmd = (rx > 0 && ry <= 0) ? jdc_pkg::CMD_ROT_CCW : jdc_pkg::CMD_ROT_CW;
        end else if (smp.left_trigger > dz_cfg) begin
            spd = scaled(int'(smp.left_trigger));
            cmd = jdc_pkg::CMD_ROT_CCW;
        end else if (smp.right_trigger > dz_cfg) begin
            spd = scaled(int'(smp.right_trigger));
            cmd = jdc_pkg::CMD_ROT_CW;
        end else begin
            spd = '0;
            cmd = jdc_pkg::CMD_STOP;
        end
        gap = smp.now_ms - sent_time;
        // the time stamp advances on every passed interval, sent or not
        if (gap >= {16'd0, interval_cfg}) begin
            sent_time = smp.now_ms;
            if (!sent_once || cmd != sent_cmd || spd != sent_speed) begin
                sent_once = 1'b1;
                sent_cmd = cmd;
                sent_speed = spd;
                beat.cmd = cmd;
                beat.speed = spd;
                drive_expect_q.push_back(beat);
            end
        end
    endtask

    // ---------------------------------------------------------------- stimulus
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            jdc_pkg::REG_DEADZONE: dz_cfg = val[7:0];
            jdc_pkg::REG_LIMIT:    limit_cfg = val[7:0];
            jdc_pkg::REG_INTERVAL: interval_cfg = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic put(input int lx, input int ly, input int rx, input int ry,
                       input int lt, input int rt, input int dt);
        t_sample smp;
        clk_ms = clk_ms + 32'(dt);
        smp.left_x = 8'(lx);
        smp.left_y = 8'(ly);
        smp.right_x = 8'(rx);
        smp.right_y = 8'(ry);
        smp.left_trigger = 8'(lt);
        smp.right_trigger = 8'(rt);
        smp.now_ms = clk_ms;
        sample_q.push_back(smp);
    endtask

    // a stick value that stays inside the deadzone
    function automatic logic [7:0] calm_axis();
        int d;
        if (dz_cfg >= 8'd128)
            return 8'($urandom);
        d = int'(dz_cfg);
        return 8'(int'($urandom_range(2 * d, 0)) - d);
    endfunction

    task automatic advance_ms();
        case ($urandom_range(9, 0))
            0:       clk_ms = $urandom;    // jump anywhere, backwards too
            1, 2:    clk_ms = clk_ms + 32'($urandom_range(int'(interval_cfg), 0));
            default: clk_ms = clk_ms + {16'd0, interval_cfg} + 32'($urandom_range(20, 0));
        endcase
    endtask

    task automatic queue_random(input int n);
        t_sample smp;
        int pick;
        repeat (n) begin
            pick = $urandom_range(99, 0);
            smp = t_sample'(80'({$urandom, $urandom, $urandom}));
            if (pick >= 40) begin
                smp.left_x = calm_axis();
                smp.left_y = calm_axis();
            end
            if (pick >= 60) begin
                smp.right_x = calm_axis();
                smp.right_y = calm_axis();
            end
            if (pick >= 70)
                smp.left_trigger = 8'($urandom_range(int'(dz_cfg), 0));
            if (pick >= 78)
                smp.right_trigger = 8'($urandom_range(int'(dz_cfg), 0));
            // repeat the previous sample so that unchanged commands get dropped
            if (pick >= 85)
                smp = last_made;
            advance_ms();
            smp.now_ms = clk_ms;
            last_made = smp;
            sample_q.push_back(smp);
        end
    endtask

    task automatic drain();
        while (sample_q.size() != 0 || s_valid || drive_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- driver
    always @(negedge i_clk) begin
        if (!s_valid || s_taken) begin
            if (sample_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                s_item <= sample_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk)
        m_ready <= !hold_rx && ($urandom_range(99, 0) >= recv_idle_pct);

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (pressure_go);
        @(negedge i_clk);
        hold_rx <= 1'b1;
        repeat (STALL_LEN) @(negedge i_clk);
        hold_rx <= 1'b0;
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        if (!rst_n) begin
            s_taken <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            s_taken <= s_valid && o_s_axis_tready;
            if (o_m_axis_tvalid && m_ready) begin
                got_beat = o_m_axis_tdata[13:0];
                if (drive_expect_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected drive beat: cmd %0d speed %0d",
                                 got_beat.cmd, got_beat.speed);
                end else begin
                    want_beat = drive_expect_q.pop_front();
                    if (got_beat.cmd != want_beat.cmd || got_beat.speed != want_beat.speed) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("drive beat mismatch: cmd %0d/%0d speed %0d/%0d (exp/got)",
                                     want_beat.cmd, got_beat.cmd,
                                     want_beat.speed, got_beat.speed);
                    end
                end
            end
            if (s_valid && o_s_axis_tready)
                decide_drive(s_item);
            if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)
                    || (cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < LIMIT) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- sequence
    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // reset settings: deadzone 10, full limit, 50 ms interval
        clk_ms = 32'd0;
        put(0, 0, 0, 0, 0, 0, 100);          // first stop is always sent
        put(0, 0, 0, 0, 0, 0, 50);           // unchanged, drop
        put(-128, 0, 0, 0, 0, 0, 60);        // right, speed above the limit
        put(127, 0, 0, 0, 0, 0, 60);
        put(0, 127, 0, 0, 0, 0, 60);
        put(0, -128, 0, 0, 0, 0, 60);
        put(-100, 100, 0, 0, 0, 0, 60);
        put(100, 100, 0, 0, 0, 0, 60);
        put(100, -100, 0, 0, 0, 0, 60);
        put(-100, -100, 0, 0, 0, 0, 60);
        put(-128, -128, 0, 0, 0, 0, 60);     // largest stick magnitude
        put(-99, 41, 0, 0, 0, 0, 60);        // just inside the horizontal sector
        put(-70, 29, 0, 0, 0, 0, 60);        // just past it, diagonal
        put(41, -99, 0, 0, 0, 0, 60);
        put(10, -10, 11, 0, 0, 0, 60);       // left at the deadzone, right counts
        put(0, 0, 11, 1, 0, 0, 60);
        put(0, 0, -128, -128, 0, 0, 60);
        put(0, 0, 0, 0, 255, 0, 60);
        put(0, 0, 0, 0, 10, 11, 60);
        put(0, 0, 0, 0, 0, 255, 49);         // interval not yet passed
        put(0, 0, 0, 0, 0, 255, 0);
        put(0, 0, 0, 0, 0, 255, 1);
        clk_ms = 32'hFFFF_FFE0;
        put(0, -128, 0, 0, 0, 0, 0);
        put(0, -128, 0, 0, 0, 0, 60);        // time wraps, same command
        put(0, 0, -11, 11, 0, 0, 50);
        clk_ms = 32'd5;
        put(0, 0, 0, 0, 0, 0, 0);            // time goes backwards
        drain();

        write_reg(jdc_pkg::REG_DEADZONE, 16'd0);
        write_reg(jdc_pkg::REG_LIMIT, 16'd255);
        write_reg(jdc_pkg::REG_INTERVAL, 16'd0);
        write_reg(REG_SPARE, 16'hFFFF);
        queue_random(250);
        pressure_go = 1'b1;
        drain();

        write_reg(jdc_pkg::REG_DEADZONE, 16'hFFFF);
        write_reg(jdc_pkg::REG_LIMIT, 16'hFF00);
        write_reg(jdc_pkg::REG_INTERVAL, 16'hFFFF);
        queue_random(60);
        drain();

        send_idle_pct = 85;
        recv_idle_pct = 12;
        write_reg(jdc_pkg::REG_DEADZONE, {8'($urandom), 8'($urandom_range(40, 0))});
        write_reg(jdc_pkg::REG_LIMIT, 16'($urandom));
        write_reg(jdc_pkg::REG_INTERVAL, 16'($urandom_range(30, 0)));
        queue_random(300);
        drain();

        write_reg(jdc_pkg::REG_DEADZONE, 16'd127);
        write_reg(jdc_pkg::REG_LIMIT, 16'd127);
        write_reg(jdc_pkg::REG_INTERVAL, 16'd1);
        queue_random(150);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(jdc_pkg::REG_DEADZONE, 16'd128);
        write_reg(jdc_pkg::REG_LIMIT, 16'd1);
        write_reg(jdc_pkg::REG_INTERVAL, 16'd50);
        queue_random(150);
        drain();

        write_reg(jdc_pkg::REG_DEADZONE, 16'($urandom_range(20, 0)));
        write_reg(jdc_pkg::REG_LIMIT, 16'($urandom_range(255, 0)));
        write_reg(jdc_pkg::REG_INTERVAL, 16'($urandom_range(100, 0)));
        queue_random(300);
        drain();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
